FILE: rtl/core/cmps_pkg.sv
// Package for the cardioid masked pixel score core.
// Holds widths, configuration codes, queue item types and the band weight function.
// No dependencies.
package cmps_pkg;

	localparam int unsigned DEF_MAX_ROWS = 1024;
	localparam int unsigned DEF_MAX_COLS = 1024;

	localparam int PIX_W     = 8;
	localparam int CXY_W     = 12;
	localparam int SZ_W      = 11;
	localparam int SZE_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	localparam int DX_W   = 14;
	localparam int SQ_W   = 26;
	localparam int D2_W   = 27;
	localparam int A_W    = 28;
	localparam int R_W    = 10;
	localparam int R2_W   = 20;
	localparam int DYM_W  = 13;
	localparam int UB_W   = 33;
	localparam int UL_W   = 17;
	localparam int A2_W   = 54;
	localparam int LHS_W  = 81;
	localparam int RHS_W  = 66;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;

	localparam int WGT_W    = 9;
	localparam int ROW_W    = 19;
	localparam int IMG_W    = 29;
	localparam int FIT_W    = 27;
	localparam int Q0_W     = 29;
	localparam int ROWIDX_W = 10;
	localparam int REM_W    = 37;

	localparam logic [Q0_W-1:0] FIT_RECIP = 29'd487372175;
	localparam int              FIT_SHIFT = 28;
	localparam logic [7:0]      FIT_DIV   = 8'd141;

	localparam int QDEPTH = 4;
	localparam int QP_W   = 2;
	localparam int QC_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X   = 3'd0,
		CFG_CENTER_Y   = 3'd1,
		CFG_SHAPE_SIZE = 3'd2,
		CFG_IMAGE_ROWS = 3'd3,
		CFG_IMAGE_COLS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CXY_W-1:0] center_x;
		logic signed [CXY_W-1:0] center_y;
		logic [SZ_W-1:0]         shape_size;
		logic [SZ_W-1:0]         image_rows;
		logic [SZ_W-1:0]         image_cols;
	} cfg_t;

	typedef enum logic [1:0] {
		K_IN    = 2'd0,
		K_OUT   = 2'd1,
		K_EXACT = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [WGT_W-1:0] weight;
		logic                    end_row;
		logic                    end_img;
		logic [ROWIDX_W-1:0]     row_idx;
	} tag_t;

	typedef struct packed {
		kind_t            kind;
		logic             a_pos;
		logic [D2_W-1:0]  ua;
		logic [UB_W-1:0]  ub;
		logic [D2_W-1:0]  d2;
		tag_t             tag;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [WGT_W-1:0] band_weight(input logic [PIX_W-1:0] pix);
		logic signed [WGT_W-1:0] w;
		if (pix < 8'd45)       w = -9'sd180;
		else if (pix < 8'd140) w = 9'sd30;
		else if (pix < 8'd200) w = 9'sd50;
		else                   w = -9'sd41;
		return w;
	endfunction

endpackage

FILE: rtl/core/cmps_if.sv
// Channel interfaces of the cardioid masked pixel score core.
// Depends on cmps_pkg.
interface cmps_pix_if;
	import cmps_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface cmps_res_if;
	import cmps_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ROWIDX_W-1:0]      row_index;
	logic signed [ROW_W-1:0]  row_sum_half;
	logic                     image_done;
	logic signed [IMG_W-1:0]  total_sum_half;
	logic [FIT_W-1:0]         fitness_q8;
	modport source (output valid, output row_index, output row_sum_half, output image_done,
		output total_sum_half, output fitness_q8, input ready);
	modport sink (input valid, input row_index, input row_sum_half, input image_done,
		input total_sum_half, input fitness_q8, output ready);
endinterface

interface cmps_cfg_if;
	import cmps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/cardioid_masked_pixel_score_core.sv
// Pixels are accepted one per cycle, while the queue is not full, into a three-stage
// geometry front end and a four-entry queue. The back end settles a pixel from the signs
// of the cardioid terms when they decide it; otherwise the exact test runs its six products
// through the single shared 32x32 multiplier. The back end takes a new item only when idle.
// A row end adds the B_ROW state, which hands its result on toward the output register,
// and an image end adds the fitness states B_FIT1 to B_FIT3. One result item per row leaves
// through a registered output; the front keeps accepting until the queue fills.
// Depends on cmps_pkg, cmps_if, cmps_front, cmps_queue and cmps_back.
module cardioid_masked_pixel_score_core
	import cmps_pkg::*;
#(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	cmps_pix_if.sink   pix,
	cmps_res_if.source res,
	cmps_cfg_if.sink   cfg
);
	cfg_t cfg_q;
	logic push, pop;
	item_t push_item, pop_item;
	q_stat_t qst;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.shape_size <= '0;
			cfg_q.image_rows <= SZ_W'(1024);
			cfg_q.image_cols <= SZ_W'(1024);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_CENTER_X:   cfg_q.center_x <= cfg.data[CXY_W-1:0];
				CFG_CENTER_Y:   cfg_q.center_y <= cfg.data[CXY_W-1:0];
				CFG_SHAPE_SIZE: cfg_q.shape_size <= cfg.data[SZ_W-1:0];
				CFG_IMAGE_ROWS: cfg_q.image_rows <= cfg.data[SZ_W-1:0];
				CFG_IMAGE_COLS: cfg_q.image_cols <= cfg.data[SZ_W-1:0];
				default: ;
			endcase
		end
	end

	cmps_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .pix(pix), .qst(qst),
		.push(push), .push_item(push_item)
	);

	cmps_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_item),
		.pop(pop), .rdata(pop_item), .st(qst)
	);

	cmps_back u_back (
		.clk(clk), .arst_n(arst_n), .item(pop_item), .qst(qst), .pop(pop), .res(res)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qst.full || pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qst.empty) else $error("queue underflow");
	a_mid_image_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.image_done) |-> (res.total_sum_half == '0 && res.fitness_q8 == '0))
		else $error("image fields set on a middle row");
endmodule

FILE: rtl/core/cmps_front.sv
// Front end: raster counters, band weight and three-stage mask geometry.
// Classifies each pixel as inside, outside or needing the exact test. Depends on cmps_pkg.
module cmps_front
	import cmps_pkg::*;
#(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	cmps_pix_if.sink   pix,
	input  q_stat_t    qst,
	output logic       push,
	output item_t      push_item
);
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SZE_W-1:0] cols_eff, rows_eff, col_nxt, row_nxt;
	logic end_row, end_img, en, acc;

	logic v_s1, v_s2, v_s3;
	tag_t tag_s1, tag_s2, tag_s3;
	logic signed [DX_W-1:0] dx_s1, dy_s1;
	logic [R_W-1:0] r_s1;
	logic [SQ_W-1:0] dx2_s2, dy2_s2;
	logic [DYM_W-1:0] dyabs_s2;
	logic dypos_s2;
	logic [R2_W-1:0] r2_s2;
	logic [D2_W-1:0] d2_s3;
	logic signed [A_W-1:0] a_s3;
	logic [UB_W-1:0] ub_s3;
	logic bneg_s3;
	logic a_pos;

	always_comb begin
		if (cfg.image_cols == '0) cols_eff = SZE_W'(1);
		else if (SZE_W'(cfg.image_cols) > SZE_W'(MAX_COLS)) cols_eff = SZE_W'(MAX_COLS);
		else cols_eff = SZE_W'(cfg.image_cols);
		if (cfg.image_rows == '0) rows_eff = SZE_W'(1);
		else if (SZE_W'(cfg.image_rows) > SZE_W'(MAX_ROWS)) rows_eff = SZE_W'(MAX_ROWS);
		else rows_eff = SZE_W'(cfg.image_rows);
	end

	assign col_nxt = SZE_W'(col_q) + SZE_W'(1);
	assign row_nxt = SZE_W'(row_q) + SZE_W'(1);
	assign end_row = col_nxt >= cols_eff;
	assign end_img = end_row && (row_nxt >= rows_eff);

	assign en = !(v_s3 && qst.full);
	assign pix.ready = en;
	assign acc = pix.valid && en;
	assign push = v_s3 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (acc) begin
				if (!end_row) begin
					col_q <= CW'(col_nxt);
				end else begin
					col_q <= '0;
					row_q <= end_img ? '0 : RW'(row_nxt);
				end
			end
			if (en) begin
				v_s1 <= pix.valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, (DX_W-1)'(col_q)}) - DX_W'(cfg.center_x);
			dy_s1 <= $signed({1'b0, (DX_W-1)'(row_q)}) - DX_W'(cfg.center_y);
			r_s1 <= cfg.shape_size[SZ_W-1:1];
			tag_s1.weight <= band_weight(pix.pixel);
			tag_s1.end_row <= end_row;
			tag_s1.end_img <= end_img;
			tag_s1.row_idx <= ROWIDX_W'(SZE_W'(row_q));

			dx2_s2 <= SQ_W'(dx_s1 * dx_s1);
			dy2_s2 <= SQ_W'(dy_s1 * dy_s1);
			dyabs_s2 <= dy_s1[DX_W-1] ? DYM_W'(-dy_s1) : DYM_W'(dy_s1);
			dypos_s2 <= !dy_s1[DX_W-1] && (dy_s1 != '0);
			r2_s2 <= R2_W'(r_s1) * R2_W'(r_s1);
			tag_s2 <= tag_s1;

			d2_s3 <= D2_W'(dx2_s2) + D2_W'(dy2_s2);
			a_s3 <= $signed({1'b0, D2_W'(dx2_s2) + D2_W'(dy2_s2)})
				- $signed({(A_W-R2_W)'(0), r2_s2});
			ub_s3 <= UB_W'(r2_s2) * UB_W'(dyabs_s2);
			bneg_s3 <= dypos_s2 && (r2_s2 != '0);
			tag_s3 <= tag_s2;
		end
	end

	assign a_pos = !a_s3[A_W-1] && (a_s3 != '0);

	always_comb begin
		push_item.a_pos = a_pos;
		push_item.ua = a_pos ? D2_W'(a_s3) : D2_W'(-a_s3);
		push_item.ub = ub_s3;
		push_item.d2 = d2_s3;
		push_item.tag = tag_s3;
		if (d2_s3 == '0) push_item.kind = K_IN;
		else if (!a_pos && !bneg_s3) push_item.kind = K_IN;
		else if (a_pos && bneg_s3) push_item.kind = K_OUT;
		else push_item.kind = K_EXACT;
	end
endmodule

FILE: rtl/core/cmps_queue.sv
// Short item queue between front and back end.
// Depends on cmps_pkg.
module cmps_queue
	import cmps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   wdata,
	input  logic    pop,
	output item_t   rdata,
	output q_stat_t st
);
	item_t mem_q [QDEPTH];
	logic [QP_W-1:0] wp_q, rp_q;
	logic [QC_W-1:0] cnt_q;

	assign st.full = cnt_q == QC_W'(QDEPTH);
	assign st.empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QP_W'(1);
			if (pop) rp_q <= rp_q + QP_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QC_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule

FILE: rtl/core/cmps_back.sv
// Back end: exact cardioid test on a shared 32x32 multiplier, row and image sums,
// fitness by reciprocal multiply, result register. Depends on cmps_pkg.
module cmps_back
	import cmps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  q_stat_t  qst,
	output logic     pop,
	cmps_res_if.source res
);
	typedef enum logic [2:0] {
		B_IDLE, B_MUL, B_CMP, B_ACC, B_ROW, B_FIT1, B_FIT2, B_FIT3
	} bstate_t;

	bstate_t state_q;
	logic [2:0] step_q;
	item_t it_q;
	logic incl_q;
	logic [PROD_W-1:0] prod_q;
	logic [A2_W-1:0] a2_q;
	logic [LHS_W-1:0] lhs_q;
	logic [RHS_W-1:0] rhs_q;
	logic [Q0_W-1:0] q0_q;
	logic signed [ROW_W-1:0] row_acc_q, wk_rsum_q;
	logic signed [IMG_W-1:0] img_acc_q, wk_total_q, tot;
	logic [FIT_W-1:0] wk_fit_q;
	logic out_pend_q, res_vld_q;
	logic [MUL_W-1:0] ma, mb;
	logic [REM_W-1:0] rem;

	assign pop = (state_q == B_IDLE) && !qst.empty && !out_pend_q;
	assign tot = img_acc_q + IMG_W'(row_acc_q);
	assign rem = {1'b0, wk_total_q[FIT_SHIFT-1:0], 8'b0} - REM_W'(prod_q);
	assign res.valid = res_vld_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			B_MUL: begin
				case (step_q)
					3'd0: begin ma = MUL_W'(it_q.ua); mb = MUL_W'(it_q.ua); end
					3'd1: begin ma = MUL_W'(prod_q[D2_W-1:0]); mb = MUL_W'(it_q.d2); end
					3'd2: begin ma = MUL_W'(a2_q[A2_W-1:D2_W]); mb = MUL_W'(it_q.d2); end
					3'd3: begin ma = MUL_W'(it_q.ub[UL_W-1:0]); mb = MUL_W'(it_q.ub[UL_W-1:0]); end
					3'd4: begin ma = MUL_W'(it_q.ub[UB_W-1:UL_W]); mb = MUL_W'(it_q.ub[UL_W-1:0]); end
					3'd5: begin ma = MUL_W'(it_q.ub[UB_W-1:UL_W]); mb = MUL_W'(it_q.ub[UB_W-1:UL_W]); end
					default: ;
				endcase
			end
			B_FIT1: begin ma = MUL_W'(wk_total_q[FIT_SHIFT-1:0]); mb = MUL_W'(FIT_RECIP); end
			B_FIT2: begin ma = MUL_W'(prod_q[FIT_SHIFT+Q0_W-1:FIT_SHIFT]); mb = MUL_W'(FIT_DIV); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(ma) * PROD_W'(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
			row_acc_q <= '0;
			img_acc_q <= '0;
			out_pend_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (out_pend_q && (!res_vld_q || res.ready)) begin
				res_vld_q <= 1'b1;
				out_pend_q <= 1'b0;
				res.row_index <= it_q.tag.row_idx;
				res.row_sum_half <= wk_rsum_q;
				res.image_done <= it_q.tag.end_img;
				res.total_sum_half <= wk_total_q;
				res.fitness_q8 <= wk_fit_q;
			end else if (res_vld_q && res.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						it_q <= item;
						step_q <= '0;
						incl_q <= item.kind == K_IN;
						state_q <= (item.kind == K_EXACT) ? B_MUL : B_ACC;
					end
				end
				B_MUL: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd1: a2_q <= prod_q[A2_W-1:0];
						3'd2: lhs_q <= LHS_W'(prod_q);
						3'd3: lhs_q <= lhs_q + (LHS_W'(prod_q) << D2_W);
						3'd4: rhs_q <= RHS_W'(prod_q);
						3'd5: rhs_q <= rhs_q + (RHS_W'(prod_q) << (UL_W + 1));
						3'd6: begin
							rhs_q <= rhs_q + (RHS_W'(prod_q) << (2 * UL_W));
							state_q <= B_CMP;
						end
						default: ;
					endcase
				end
				B_CMP: begin
					incl_q <= it_q.a_pos ? (lhs_q <= LHS_W'(rhs_q)) : (LHS_W'(rhs_q) <= lhs_q);
					state_q <= B_ACC;
				end
				B_ACC: begin
					if (incl_q) row_acc_q <= row_acc_q + ROW_W'(it_q.tag.weight);
					state_q <= it_q.tag.end_row ? B_ROW : B_IDLE;
				end
				B_ROW: begin
					wk_rsum_q <= row_acc_q;
					row_acc_q <= '0;
					if (it_q.tag.end_img) begin
						wk_total_q <= tot;
						img_acc_q <= '0;
						state_q <= B_FIT1;
					end else begin
						img_acc_q <= tot;
						wk_total_q <= '0;
						wk_fit_q <= '0;
						out_pend_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				B_FIT1: begin
					if (wk_total_q[IMG_W-1] || (wk_total_q == '0)) begin
						wk_fit_q <= '0;
						out_pend_q <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_FIT2;
					end
				end
				B_FIT2: begin
					q0_q <= prod_q[FIT_SHIFT+Q0_W-1:FIT_SHIFT];
					state_q <= B_FIT3;
				end
				B_FIT3: begin
					wk_fit_q <= FIT_W'(q0_q + ((rem >= REM_W'(FIT_DIV)) ? Q0_W'(1) : Q0_W'(0)));
					out_pend_q <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
